FILE: hdl/bts_pkg.sv
// Shared types, constants and codes of the bilinear texture sampler.
package bts_pkg;

  localparam int TEX_BITS   = 8;
  localparam int MAX_WIDTH  = 1 << TEX_BITS;
  localparam int MAX_HEIGHT = 1 << TEX_BITS;
  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 32;
  localparam int COLOR_W    = 32;
  localparam int SIZE_W     = TEX_BITS + 1;
  localparam int CFG_W      = SIZE_W;
  localparam int BANK_AW    = 2 * (TEX_BITS - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int PROD_W     = COORD_W - 1 + SIZE_W;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = COLOR_W / CH_W;
  localparam int WGT_W      = FRAC_BITS + 1;
  localparam int LERP_W     = CH_W + WGT_W;
  localparam int SUM_W      = LERP_W + WGT_W;

  localparam logic [COLOR_W-1:0] SENTINEL_COLOR = 32'hFFFF_FF00;

  typedef enum logic [1:0] {
    CFG_TEX_WIDTH   = 2'd0,
    CFG_TEX_HEIGHT  = 2'd1,
    CFG_WRAP_MODE   = 2'd2,
    CFG_FILTER_MODE = 2'd3
  } cfg_index_t;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_t;

  typedef struct packed {
    logic                      action;
    logic [TEX_BITS-1:0]       texel_u;
    logic [TEX_BITS-1:0]       texel_v;
    logic [COLOR_W-1:0]        texel_color;
    logic signed [COORD_W-1:0] coord_s;
    logic signed [COORD_W-1:0] coord_t;
  } in_word_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               used_nearest;
    logic               negative_coord;
  } out_word_t;

  // Effective (clamped) texture setup
  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic              wrap;
    logic              filter;
  } cfg_t;

  // Per-sample control that travels alongside the bank reads
  typedef struct packed {
    logic                 valid;
    logic                 negative;
    logic                 nearest;
    logic [1:0]           sel_a;
    logic [1:0]           sel_b;
    logic [1:0]           sel_c;
    logic [1:0]           sel_d;
    logic [FRAC_BITS-1:0] x;
    logic [FRAC_BITS-1:0] y;
  } side_t;

  // Bank access request: one write and four reads per cycle
  typedef struct packed {
    logic                         wr;
    logic [1:0]                   wr_bank;
    logic [BANK_AW-1:0]           wr_addr;
    logic [COLOR_W-1:0]           wr_data;
    logic [3:0][BANK_AW-1:0]      rd_addr;
  } tex_req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] a;
    logic [COLOR_W-1:0] b;
    logic [COLOR_W-1:0] c;
    logic [COLOR_W-1:0] d;
  } quad_t;

endpackage

FILE: hdl/bts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/bts_coord.sv
// Coordinate unit: scale, edge decision, neighbor indices and bank addresses.
module bts_coord (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  bts_pkg::in_word_t in_word,
  input  bts_pkg::cfg_t     cfg,
  output bts_pkg::tex_req_t req,
  output bts_pkg::side_t    side
);

  localparam logic [bts_pkg::PROD_W-1:0] HALF_FX =
    bts_pkg::PROD_W'(1) << (bts_pkg::FRAC_BITS - 1);

  // stage 1: captured word
  logic              st1_valid_r;
  bts_pkg::in_word_t st1_word_r;

  // stage 2: scaled coordinates
  logic                                st2_valid_r;
  logic                                st2_act_r;
  logic                                st2_neg_r;
  logic [bts_pkg::PROD_W-1:0]          st2_uf_r;
  logic [bts_pkg::PROD_W-1:0]          st2_vf_r;
  logic [bts_pkg::TEX_BITS-1:0]        st2_u_r;
  logic [bts_pkg::TEX_BITS-1:0]        st2_v_r;
  logic [bts_pkg::COLOR_W-1:0]         st2_color_r;

  logic [bts_pkg::COORD_W-2:0] s_in;
  logic [bts_pkg::COORD_W-2:0] t_in;
  logic [bts_pkg::PROD_W-1:0]  st2_uf_nxt;
  logic [bts_pkg::PROD_W-1:0]  st2_vf_nxt;
  logic                        st2_neg_nxt;

  logic                         near;
  logic [bts_pkg::TEX_BITS-1:0] ucol;
  logic [bts_pkg::TEX_BITS-1:0] vrow;
  logic [bts_pkg::TEX_BITS-1:0] ucol1;
  logic [bts_pkg::TEX_BITS-1:0] vrow1;
  logic                         up1;
  logic                         vp1;

  function automatic logic edge_near(input logic [bts_pkg::PROD_W-1:0] f,
                                     input logic [bts_pkg::SIZE_W-1:0] sz);
    logic [bts_pkg::PROD_W-1:0] lim;
    lim = (bts_pkg::PROD_W'(sz) << bts_pkg::FRAC_BITS) - HALF_FX;
    return (f < HALF_FX) || (f > lim);
  endfunction

  function automatic logic [bts_pkg::TEX_BITS-1:0] last_idx(
      input logic [bts_pkg::SIZE_W-1:0] sz);
    logic [bts_pkg::SIZE_W-1:0] last;
    last = sz - 1'b1;
    return last[bts_pkg::TEX_BITS-1:0];
  endfunction

  function automatic logic [bts_pkg::TEX_BITS-1:0] near_idx(
      input logic [bts_pkg::PROD_W-1:0] f,
      input logic [bts_pkg::SIZE_W-1:0] sz);
    logic [bts_pkg::PROD_W-bts_pkg::FRAC_BITS-1:0] full;
    logic [bts_pkg::SIZE_W-1:0]                    last;
    full = f[bts_pkg::PROD_W-1:bts_pkg::FRAC_BITS];
    last = sz - 1'b1;
    if (full > (bts_pkg::PROD_W - bts_pkg::FRAC_BITS)'(last)) begin
      return last[bts_pkg::TEX_BITS-1:0];
    end
    return full[bts_pkg::TEX_BITS-1:0];
  endfunction

  function automatic logic [bts_pkg::BANK_AW-1:0] bank_addr(
      input logic [1:0]                   bk,
      input logic [bts_pkg::TEX_BITS-1:0] c0,
      input logic [bts_pkg::TEX_BITS-1:0] c1,
      input logic [bts_pkg::TEX_BITS-1:0] r0,
      input logic [bts_pkg::TEX_BITS-1:0] r1);
    logic [bts_pkg::TEX_BITS-1:0] col;
    logic [bts_pkg::TEX_BITS-1:0] row;
    col = (bk[0] == c0[0]) ? c0 : c1;
    row = (bk[1] == r0[0]) ? r0 : r1;
    return {row[bts_pkg::TEX_BITS-1:1], col[bts_pkg::TEX_BITS-1:1]};
  endfunction

  // capture the accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_valid_r <= 1'b0;
    end else begin
      st1_valid_r <= in_valid;
    end
    st1_word_r <= in_word;
  end

  // wrap and scale both coordinates
  always_comb begin
    if (cfg.wrap) begin
      s_in = (bts_pkg::COORD_W-1)'(st1_word_r.coord_s[bts_pkg::FRAC_BITS-1:0]);
      t_in = (bts_pkg::COORD_W-1)'(st1_word_r.coord_t[bts_pkg::FRAC_BITS-1:0]);
    end else begin
      s_in = st1_word_r.coord_s[bts_pkg::COORD_W-2:0];
      t_in = st1_word_r.coord_t[bts_pkg::COORD_W-2:0];
    end
    st2_uf_nxt  = bts_pkg::PROD_W'(s_in) * bts_pkg::PROD_W'(cfg.width);
    st2_vf_nxt  = bts_pkg::PROD_W'(t_in) * bts_pkg::PROD_W'(cfg.height);
    st2_neg_nxt = st1_word_r.coord_s[bts_pkg::COORD_W-1] |
                  st1_word_r.coord_t[bts_pkg::COORD_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st2_valid_r <= 1'b0;
    end else begin
      st2_valid_r <= st1_valid_r;
    end
    st2_act_r   <= st1_word_r.action;
    st2_neg_r   <= st2_neg_nxt;
    st2_uf_r    <= st2_uf_nxt;
    st2_vf_r    <= st2_vf_nxt;
    st2_u_r     <= st1_word_r.texel_u;
    st2_v_r     <= st1_word_r.texel_v;
    st2_color_r <= st1_word_r.texel_color;
  end

  // pick the base texel and the clamped neighbors
  always_comb begin
    logic [bts_pkg::PROD_W-1:0] us;
    logic [bts_pkg::PROD_W-1:0] vs;
    us   = st2_uf_r - HALF_FX;
    vs   = st2_vf_r - HALF_FX;
    near = !cfg.filter || edge_near(st2_uf_r, cfg.width) ||
           edge_near(st2_vf_r, cfg.height);
    if (near) begin
      ucol = near_idx(st2_uf_r, cfg.width);
      vrow = near_idx(st2_vf_r, cfg.height);
    end else begin
      ucol = us[bts_pkg::FRAC_BITS +: bts_pkg::TEX_BITS];
      vrow = vs[bts_pkg::FRAC_BITS +: bts_pkg::TEX_BITS];
    end
    ucol1 = ucol + 1'b1;
    vrow1 = vrow + 1'b1;
    up1   = (ucol == last_idx(cfg.width))  ? ucol[0] : ~ucol[0];
    vp1   = (vrow == last_idx(cfg.height)) ? vrow[0] : ~vrow[0];

    side.valid    = st2_valid_r && (st2_act_r == bts_pkg::ACT_SAMPLE);
    side.negative = st2_neg_r;
    side.nearest  = near;
    side.sel_a    = {vrow[0], ucol[0]};
    side.sel_b    = {vp1, ucol[0]};
    side.sel_c    = {vp1, up1};
    side.sel_d    = {vrow[0], up1};
    side.x        = us[bts_pkg::FRAC_BITS-1:0];
    side.y        = vs[bts_pkg::FRAC_BITS-1:0];
  end

  // bank requests
  always_comb begin
    req.wr      = st2_valid_r && (st2_act_r == bts_pkg::ACT_WRITE);
    req.wr_bank = {st2_v_r[0], st2_u_r[0]};
    req.wr_addr = {st2_v_r[bts_pkg::TEX_BITS-1:1], st2_u_r[bts_pkg::TEX_BITS-1:1]};
    req.wr_data = st2_color_r;
    for (int b = 0; b < 4; b++) begin
      req.rd_addr[b] = bank_addr(2'(b), ucol, ucol1, vrow, vrow1);
    end
  end

endmodule

FILE: hdl/bts_texmem.sv
// Texel store: four parity banks, one read each per cycle, neighbor select.
module bts_texmem (
  input  logic              clk,
  input  logic              rst_n,
  input  bts_pkg::tex_req_t req,
  input  bts_pkg::side_t    side,
  output bts_pkg::side_t    side_out,
  output bts_pkg::quad_t    quad
);

  logic [bts_pkg::COLOR_W-1:0] rdata [4];
  bts_pkg::side_t              side_r;

  // one bank per (row parity, column parity)
  for (genvar b = 0; b < 4; b++) begin : g_bank
    bts_ram #(
      .WIDTH (bts_pkg::COLOR_W),
      .DEPTH (bts_pkg::BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (req.wr && (req.wr_bank == 2'(b))),
      .waddr (req.wr_addr),
      .wdata (req.wr_data),
      .raddr (req.rd_addr[b]),
      .rdata (rdata[b])
    );
  end

  // hold control aligned with the read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else begin
      side_r.valid <= side.valid;
    end
    side_r.negative <= side.negative;
    side_r.nearest  <= side.nearest;
    side_r.sel_a    <= side.sel_a;
    side_r.sel_b    <= side.sel_b;
    side_r.sel_c    <= side.sel_c;
    side_r.sel_d    <= side.sel_d;
    side_r.x        <= side.x;
    side_r.y        <= side.y;
  end

  assign side_out = side_r;
  assign quad.a   = rdata[side_r.sel_a];
  assign quad.b   = rdata[side_r.sel_b];
  assign quad.c   = rdata[side_r.sel_c];
  assign quad.d   = rdata[side_r.sel_d];

endmodule

FILE: hdl/bts_blend.sv
// Blend unit: two lerp stages per channel and the result register.
module bts_blend (
  input  logic               clk,
  input  logic               rst_n,
  input  bts_pkg::side_t     side,
  input  bts_pkg::quad_t     quad,
  output logic               out_strobe,
  output bts_pkg::out_word_t out_word
);

  localparam logic [bts_pkg::WGT_W-1:0] ONE_FX =
    bts_pkg::WGT_W'(1) << bts_pkg::FRAC_BITS;

  logic                              st4_valid_r;
  logic                              st4_negative_r;
  logic                              st4_nearest_r;
  logic [bts_pkg::COLOR_W-1:0]       st4_near_color_r;
  logic [bts_pkg::FRAC_BITS-1:0]     st4_y_r;
  logic [bts_pkg::LERP_W-1:0]        st4_lo_r [bts_pkg::NUM_CH];
  logic [bts_pkg::LERP_W-1:0]        st4_hi_r [bts_pkg::NUM_CH];
  logic [bts_pkg::LERP_W-1:0]        st4_lo_nxt [bts_pkg::NUM_CH];
  logic [bts_pkg::LERP_W-1:0]        st4_hi_nxt [bts_pkg::NUM_CH];

  logic                              out_valid_r;
  bts_pkg::out_word_t                out_word_r;
  bts_pkg::out_word_t                out_word_nxt;
  logic [bts_pkg::COLOR_W-1:0]       mix;

  // horizontal lerp per channel
  always_comb begin
    logic [bts_pkg::WGT_W-1:0] wx;
    logic [bts_pkg::WGT_W-1:0] ox;
    wx = bts_pkg::WGT_W'(side.x);
    ox = ONE_FX - wx;
    for (int k = 0; k < bts_pkg::NUM_CH; k++) begin
      st4_lo_nxt[k] = bts_pkg::LERP_W'(quad.a[k*bts_pkg::CH_W +: bts_pkg::CH_W] * ox) +
                      bts_pkg::LERP_W'(quad.d[k*bts_pkg::CH_W +: bts_pkg::CH_W] * wx);
      st4_hi_nxt[k] = bts_pkg::LERP_W'(quad.b[k*bts_pkg::CH_W +: bts_pkg::CH_W] * ox) +
                      bts_pkg::LERP_W'(quad.c[k*bts_pkg::CH_W +: bts_pkg::CH_W] * wx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st4_valid_r <= 1'b0;
    end else begin
      st4_valid_r <= side.valid;
    end
    st4_negative_r   <= side.negative;
    st4_nearest_r    <= side.nearest;
    st4_near_color_r <= quad.a;
    st4_y_r          <= side.y;
    for (int k = 0; k < bts_pkg::NUM_CH; k++) begin
      st4_lo_r[k] <= st4_lo_nxt[k];
      st4_hi_r[k] <= st4_hi_nxt[k];
    end
  end

  // vertical lerp, truncate and saturate each channel
  always_comb begin
    logic [bts_pkg::WGT_W-1:0]               wy;
    logic [bts_pkg::WGT_W-1:0]               oy;
    logic [bts_pkg::SUM_W-1:0]               sum;
    logic [bts_pkg::SUM_W-2*bts_pkg::FRAC_BITS-1:0] ch;
    wy = bts_pkg::WGT_W'(st4_y_r);
    oy = ONE_FX - wy;
    mix = '0;
    for (int k = 0; k < bts_pkg::NUM_CH; k++) begin
      sum = bts_pkg::SUM_W'(st4_lo_r[k] * oy) + bts_pkg::SUM_W'(st4_hi_r[k] * wy);
      ch  = sum[bts_pkg::SUM_W-1:2*bts_pkg::FRAC_BITS];
      if (ch > (bts_pkg::SUM_W-2*bts_pkg::FRAC_BITS)'({bts_pkg::CH_W{1'b1}})) begin
        mix[k*bts_pkg::CH_W +: bts_pkg::CH_W] = {bts_pkg::CH_W{1'b1}};
      end else begin
        mix[k*bts_pkg::CH_W +: bts_pkg::CH_W] = ch[bts_pkg::CH_W-1:0];
      end
    end
  end

  // choose the result word
  always_comb begin
    if (st4_negative_r) begin
      out_word_nxt.color          = bts_pkg::SENTINEL_COLOR;
      out_word_nxt.used_nearest   = 1'b0;
      out_word_nxt.negative_coord = 1'b1;
    end else if (st4_nearest_r) begin
      out_word_nxt.color          = st4_near_color_r;
      out_word_nxt.used_nearest   = 1'b1;
      out_word_nxt.negative_coord = 1'b0;
    end else begin
      out_word_nxt.color          = mix;
      out_word_nxt.used_nearest   = 1'b0;
      out_word_nxt.negative_coord = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= st4_valid_r;
    end
    out_word_r <= out_word_nxt;
  end

  assign out_strobe = out_valid_r;
  assign out_word   = out_word_r;

endmodule

FILE: hdl/bilinear_texture_sampler_unit.sv
// Top level of the bilinear texture sampler: setup registers and pipeline.
//
//  channel   direction  handshake            word
//  in_       input      start, busy          in_word (write texel or sample)
//  out_      output     out_strobe           out_word (one per sample)
//  cfg_      input      cfg_we, cfg_index    cfg_data (9 bits)
//
// One word per clock. A sample's result passes the input, scaled-coordinate,
// bank-read, horizontal-lerp and result registers to out_word; a texel write is
// visible to a sample taken on the next cycle.
// The texel store is four parity banks so all four neighbors read at once.
// busy stays low: nothing holds the input off. rst_n (synchronous) clears
// the pipeline and loads the setup defaults; texel contents are kept.
// out_strobe is high for one cycle per result; the receiver cannot stall.
module bilinear_texture_sampler_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  bts_pkg::in_word_t          in_word,
  output logic                       out_strobe,
  output bts_pkg::out_word_t         out_word,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [bts_pkg::CFG_W-1:0]  cfg_data
);

  logic [bts_pkg::SIZE_W-1:0] tex_width_r;
  logic [bts_pkg::SIZE_W-1:0] tex_height_r;
  logic                       wrap_mode_r;
  logic                       filter_mode_r;
  bts_pkg::cfg_t              cfg;
  bts_pkg::tex_req_t          req;
  bts_pkg::side_t             side_req;
  bts_pkg::side_t             side_rd;
  bts_pkg::quad_t             quad;
  logic                       accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // setup registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r   <= bts_pkg::SIZE_W'(bts_pkg::MAX_WIDTH);
      tex_height_r  <= bts_pkg::SIZE_W'(bts_pkg::MAX_HEIGHT);
      wrap_mode_r   <= 1'b1;
      filter_mode_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        bts_pkg::CFG_TEX_WIDTH:   tex_width_r   <= cfg_data;
        bts_pkg::CFG_TEX_HEIGHT:  tex_height_r  <= cfg_data;
        bts_pkg::CFG_WRAP_MODE:   wrap_mode_r   <= cfg_data[0];
        bts_pkg::CFG_FILTER_MODE: filter_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp sizes to the usable range
  always_comb begin
    if (tex_width_r == '0) begin
      cfg.width = bts_pkg::SIZE_W'(1);
    end else if (tex_width_r > bts_pkg::SIZE_W'(bts_pkg::MAX_WIDTH)) begin
      cfg.width = bts_pkg::SIZE_W'(bts_pkg::MAX_WIDTH);
    end else begin
      cfg.width = tex_width_r;
    end
    if (tex_height_r == '0) begin
      cfg.height = bts_pkg::SIZE_W'(1);
    end else if (tex_height_r > bts_pkg::SIZE_W'(bts_pkg::MAX_HEIGHT)) begin
      cfg.height = bts_pkg::SIZE_W'(bts_pkg::MAX_HEIGHT);
    end else begin
      cfg.height = tex_height_r;
    end
    cfg.wrap   = wrap_mode_r;
    cfg.filter = filter_mode_r;
  end

  bts_coord u_coord (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_word  (in_word),
    .cfg      (cfg),
    .req      (req),
    .side     (side_req)
  );

  bts_texmem u_texmem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .side     (side_req),
    .side_out (side_rd),
    .quad     (quad)
  );

  bts_blend u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .side       (side_rd),
    .quad       (quad),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  // every accepted sample gives a result word
  a_sample_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_word.action == bts_pkg::ACT_SAMPLE) |-> ##5 out_strobe)
    else $error("sample produced no result word");

  // a texel write never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_word.action == bts_pkg::ACT_WRITE) |-> ##5 !out_strobe)
    else $error("texel write produced a result word");

  // a negative coordinate always returns the sentinel and no nearest flag
  a_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.negative_coord) |->
      (out_word.color == bts_pkg::SENTINEL_COLOR && !out_word.used_nearest))
    else $error("negative coordinate without sentinel");

endmodule

FILE: tb/bilinear_texture_sampler_unit_test.sv
// Self-checking testbench for the bilinear texture sampler top level.
module bilinear_texture_sampler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int PRELOAD_SIZE   = 16;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  bts_pkg::in_word_t in_word;
  logic out_strobe;
  bts_pkg::out_word_t out_word;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [bts_pkg::CFG_W-1:0] cfg_data;

  bilinear_texture_sampler_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: texel store and setup registers
  logic [bts_pkg::COLOR_W-1:0] texels [bts_pkg::MAX_WIDTH*bts_pkg::MAX_HEIGHT];
  logic [bts_pkg::SIZE_W-1:0] width_reg, height_reg;
  logic wrap_reg, filter_reg;

  bts_pkg::out_word_t expected_colors[$];
  int errors = 0;
  int n_writes = 0, n_samples = 0, n_checked = 0, n_nearest = 0, n_negative = 0;
  int gap_pct = 0;
  int idle_cycles = 0;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [63:0] eff_size(input logic [bts_pkg::SIZE_W-1:0] r);
    if (r == 0) return 64'd1;
    if (r > bts_pkg::MAX_WIDTH) return 64'(bts_pkg::MAX_WIDTH);
    return 64'(r);
  endfunction

  function automatic logic [31:0] texel_at(input logic [63:0] u, input logic [63:0] v,
                                           input logic [63:0] w, input logic [63:0] h);
    logic [63:0] cu, cv;
    cu = (u > w - 1) ? w - 1 : u;
    cv = (v > h - 1) ? h - 1 : v;
    return texels[cv * bts_pkg::MAX_WIDTH + cu];
  endfunction

  function automatic logic [31:0] blend_quad(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d,
                                             input logic [63:0] x, input logic [63:0] y);
    logic [31:0] res;
    logic [63:0] lo, hi, sum, ch, one;
    res = '0;
    one = 64'd1 << bts_pkg::FRAC_BITS;
    for (int sh = 0; sh < 32; sh += 8) begin
      lo = 64'(a[sh+:8]) * (one - x) + 64'(d[sh+:8]) * x;
      hi = 64'(b[sh+:8]) * (one - x) + 64'(c[sh+:8]) * x;
      sum = lo * (one - y) + hi * y;
      ch = sum >> (2 * bts_pkg::FRAC_BITS);
      if (ch > 255) ch = 255;
      res[sh+:8] = ch[7:0];
    end
    return res;
  endfunction

  // Compute the sampled color for one sample word
  function automatic bts_pkg::out_word_t sample_texture(input bts_pkg::in_word_t w);
    bts_pkg::out_word_t r;
    logic [63:0] s, t, wd, ht, uf, vf, us, vs, ua, va, one, half;
    one = 64'd1 << bts_pkg::FRAC_BITS;
    half = 64'd1 << (bts_pkg::FRAC_BITS - 1);
    s = 64'(unsigned'(w.coord_s));
    t = 64'(unsigned'(w.coord_t));
    if (s[31] || t[31]) begin
      r.color = bts_pkg::SENTINEL_COLOR;
      r.used_nearest = 1'b0;
      r.negative_coord = 1'b1;
      return r;
    end
    wd = eff_size(width_reg);
    ht = eff_size(height_reg);
    if (wrap_reg) begin
      s = s & (one - 1);
      t = t & (one - 1);
    end
    uf = s * wd;
    vf = t * ht;
    r.negative_coord = 1'b0;
    if (!filter_reg || uf < half || vf < half || uf > wd * one - half ||
        vf > ht * one - half) begin
      r.color = texel_at(uf >> bts_pkg::FRAC_BITS, vf >> bts_pkg::FRAC_BITS, wd, ht);
      r.used_nearest = 1'b1;
      return r;
    end
    us = uf - half;
    vs = vf - half;
    ua = us >> bts_pkg::FRAC_BITS;
    va = vs >> bts_pkg::FRAC_BITS;
    r.color = blend_quad(texel_at(ua, va, wd, ht), texel_at(ua, va + 1, wd, ht),
                         texel_at(ua + 1, va + 1, wd, ht), texel_at(ua + 1, va, wd, ht),
                         us & (one - 1), vs & (one - 1));
    r.used_nearest = 1'b0;
    return r;
  endfunction

  // Send one word, with an optional random gap first, then predict it
  task automatic send_word(input bts_pkg::in_word_t w);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (w.action == bts_pkg::ACT_WRITE) begin
      texels[{w.texel_v, w.texel_u}] = w.texel_color;
      n_writes++;
    end else begin
      expected_colors.push_back(sample_texture(w));
      n_samples++;
    end
  endtask

  // Hold input low until every expected result is back, plus pipeline slack
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all four setup registers while idle
  task automatic set_config(input int w, input int h, input bit wrap, input bit filt);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= bts_pkg::CFG_TEX_WIDTH;
    cfg_data <= bts_pkg::CFG_W'(w);
    @(posedge clk);
    width_reg = bts_pkg::SIZE_W'(w);
    cfg_index <= bts_pkg::CFG_TEX_HEIGHT;
    cfg_data <= bts_pkg::CFG_W'(h);
    @(posedge clk);
    height_reg = bts_pkg::SIZE_W'(h);
    cfg_index <= bts_pkg::CFG_WRAP_MODE;
    cfg_data <= bts_pkg::CFG_W'(wrap);
    @(posedge clk);
    wrap_reg = wrap;
    cfg_index <= bts_pkg::CFG_FILTER_MODE;
    cfg_data <= bts_pkg::CFG_W'(filt);
    @(posedge clk);
    filter_reg = filt;
    cfg_we <= 1'b0;
  endtask

  function automatic bts_pkg::in_word_t texel_word(input int u, input int v,
                                                   input logic [31:0] c);
    bts_pkg::in_word_t w;
    w = '0;
    w.action = bts_pkg::ACT_WRITE;
    w.texel_u = u[7:0];
    w.texel_v = v[7:0];
    w.texel_color = c;
    w.coord_s = $urandom();
    w.coord_t = $urandom();
    return w;
  endfunction

  function automatic bts_pkg::in_word_t sample_word(input logic [31:0] s,
                                                    input logic [31:0] t);
    bts_pkg::in_word_t w;
    w.action = bts_pkg::ACT_SAMPLE;
    w.texel_u = $urandom();
    w.texel_v = $urandom();
    w.texel_color = $urandom();
    w.coord_s = s;
    w.coord_t = t;
    return w;
  endfunction

  // Random coordinate: edges, in-range or full range, rarely negative
  function automatic logic [31:0] rand_coord(input int size);
    logic [31:0] c;
    int sel;
    sel = $urandom_range(99);
    if (sel < 20) c = $urandom_range(0, 1 << bts_pkg::FRAC_BITS) / ((size < 1) ? 1 : size);
    else if (sel < 35) c = (1 << bts_pkg::FRAC_BITS) - $urandom_range(0, 600);
    else if (sel < 70)
      c = $urandom_range(0, ((size < 1) ? 1 : size) * (1 << bts_pkg::FRAC_BITS) + 200);
    else c = {1'b0, 31'($urandom())};
    if ($urandom_range(99) < 8) c[31] = 1'b1;
    return c;
  endfunction

  task automatic random_items(input int count, input int size);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 20)
        send_word(texel_word($urandom_range(0, 255), $urandom_range(0, 255), $urandom()));
      else
        send_word(sample_word(rand_coord(size), rand_coord(size)));
    end
  endtask

  // Fill the corner block that every random setup stays inside
  task automatic test_preload;
    gap_pct = 0;
    for (int v = 0; v < PRELOAD_SIZE; v++)
      for (int u = 0; u < PRELOAD_SIZE; u++)
        send_word(texel_word(u, v, $urandom()));
  endtask

  // Edge cases; every texel they reach is written first
  task automatic test_directed;
    send_word(texel_word(255, 255, 32'hFFFF_FFFF));
    send_word(texel_word(0, 0, 32'h0000_0000));
    send_word(texel_word(255, 127, $urandom()));
    send_word(texel_word(255, 128, $urandom()));
    send_word(texel_word(0, 127, $urandom()));
    send_word(texel_word(0, 128, $urandom()));
    send_word(texel_word(0, 255, $urandom()));
    send_word(texel_word(255, 0, $urandom()));
    send_word(sample_word(32'h0, 32'h0));
    send_word(sample_word(32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_word(sample_word(32'hFFFF_FFFF, 32'h0));
    send_word(sample_word(32'h0, 32'h8000_0000));
    send_word(sample_word(32'h0000_0080, 32'h0000_0080));
    send_word(sample_word(32'h0000_FF80, 32'h0000_8000));
    set_config(0, 511, 0, 1);
    send_word(sample_word(32'h0001_0000, 32'h00FF_8000));
    send_word(sample_word(32'h0000_8000, 32'h0000_8000));
    set_config(1, 1, 1, 0);
    send_word(sample_word(32'h0000_C000, 32'h0000_4000));
    set_config(256, 256, 0, 0);
    send_word(sample_word(32'h0100_0000, 32'h00FF_FFFF));
    send_word(sample_word(32'h0000_FFFF, 32'h0000_0001));
    set_config(256, 256, 0, 1);
    send_word(sample_word(32'h00FF_7FFF, 32'h0000_8001));
    send_word(sample_word(32'h00FF_8001, 32'h0080_0000));
  endtask

  task automatic test_bilinear_random;
    set_config(PRELOAD_SIZE, PRELOAD_SIZE, 1, 1);
    gap_pct = 0;
    random_items(100, PRELOAD_SIZE);
    set_config($urandom_range(2, PRELOAD_SIZE), $urandom_range(2, PRELOAD_SIZE), 1, 1);
    gap_pct = 45;
    random_items(100, PRELOAD_SIZE);
  endtask

  task automatic test_wrap_off;
    set_config(5, 3, 0, 1);
    gap_pct = 26;
    random_items(100, 5);
    set_config(PRELOAD_SIZE, 7, 0, 1);
    gap_pct = 0;
    random_items(70, PRELOAD_SIZE);
  endtask

  task automatic test_nearest_random;
    set_config(9, PRELOAD_SIZE, 1, 0);
    gap_pct = 45;
    random_items(80, 9);
    set_config(1, PRELOAD_SIZE, 0, 0);
    gap_pct = 0;
    random_items(70, 1);
  endtask

  // Pause the sender until every result is back, then continue
  task automatic test_pressure;
    set_config(4, 4, 1, 1);
    gap_pct = 26;
    random_items(70, 4);
    start <= 1'b0;
    @(posedge clk);
    while (expected_colors.size() != 0) @(posedge clk);
    random_items(70, 4);
  endtask

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    bts_pkg::out_word_t exp_w;
    if (rst_n && out_strobe) begin
      if (expected_colors.size() == 0) begin
        report_mismatch($sformatf("unexpected result color=%h", out_word.color));
      end else begin
        exp_w = expected_colors.pop_front();
        n_checked++;
        if (exp_w.used_nearest) n_nearest++;
        if (exp_w.negative_coord) n_negative++;
        if (out_word.color !== exp_w.color)
          report_mismatch($sformatf("color %h expected %h", out_word.color, exp_w.color));
        if (out_word.used_nearest !== exp_w.used_nearest)
          report_mismatch($sformatf("used_nearest %b expected %b",
                                    out_word.used_nearest, exp_w.used_nearest));
        if (out_word.negative_coord !== exp_w.negative_coord)
          report_mismatch($sformatf("negative_coord %b expected %b",
                                    out_word.negative_coord, exp_w.negative_coord));
      end
    end
  end

  // Watchdog: end the run after too many cycles with no traffic
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || cfg_we || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_colors.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    start = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = bts_pkg::CFG_TEX_WIDTH;
    cfg_data = '0;
    rst_n = 1'b0;
    width_reg = bts_pkg::SIZE_W'(bts_pkg::MAX_WIDTH);
    height_reg = bts_pkg::SIZE_W'(bts_pkg::MAX_HEIGHT);
    wrap_reg = 1'b1;
    filter_reg = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_preload();
    test_directed();
    test_bilinear_random();
    test_wrap_off();
    test_nearest_random();
    test_pressure();
    drain();
    if (expected_colors.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_colors.size()));
    $display("Covered %0d texel writes and %0d samples over several size, wrap and filter setups",
             n_writes, n_samples);
    $display("Checked %0d results: %0d nearest, %0d negative-coordinate sentinels",
             n_checked, n_nearest, n_negative);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
